/* rtl/bellows_button_note_events_macros.svh */
// Assertion macros shared by the bellows button note event RTL.
`ifndef BELLOWS_BUTTON_NOTE_EVENTS_MACROS_SVH
`define BELLOWS_BUTTON_NOTE_EVENTS_MACROS_SVH

// Check a condition at every edge outside reset.
`define BBNE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define BBNE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define BBNE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bbne_pkg.sv */
// Types, codes and helpers shared by the bellows button note event RTL.
package bbne_pkg;

    localparam int IDX_W    = 4;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int OCT_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;
    localparam int SUM_W    = 9;

    localparam int INDEX_SPAN           = 16;
    localparam int DEFAULT_BUTTON_COUNT = 16;

    localparam logic [OCT_W-1:0] OCTAVE_RESET   = 4'd3;
    localparam logic [VEL_W-1:0] VELOCITY_RESET = 7'd127;
    localparam logic [NOTE_W-1:0] NOTE_MAX      = 7'd127;

    localparam logic KIND_SCAN = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY = 2'd1;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_ON   = 2'd1,
        EV_OFF  = 2'd2
    } t_event;

    typedef struct packed {
        t_event              ev;
        logic [NOTE_W-1:0]   note;
        logic [VEL_W-1:0]    vel;
        logic                pressed;
        logic                last;
    } t_result;

    // Table note plus twelve per octave, saturated at the top note.
    function automatic logic [NOTE_W-1:0] shift_note(
        input logic [NOTE_W-1:0] note,
        input logic [OCT_W-1:0]  oct
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(note) + SUM_W'({oct, 3'b000}) + SUM_W'({oct, 2'b00});
        return (sum > SUM_W'(NOTE_MAX)) ? NOTE_MAX : sum[NOTE_W-1:0];
    endfunction

endpackage

/* rtl/bbne_res_buf.sv */
// Two-entry result buffer that releases the events of one scan in order.
`include "bellows_button_note_events_macros.svh"

module bbne_res_buf import bbne_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [1:0] i_count,
    input  t_result    i_res0,
    input  t_result    i_res1,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_res
);

    t_result    r_slot [2];
    logic [1:0] r_cnt;
    logic       w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_slot[0];
    assign w_pop   = o_valid && i_ready;
    // Room once the buffer drains this cycle.
    assign o_room  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_count;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot[0] <= i_res0;
            r_slot[1] <= i_res1;
        end else if (w_pop) begin
            r_slot[0] <= r_slot[1];
        end
    end

    `BBNE_ASSERT_ALWAYS(a_cnt_range, r_cnt != 2'd3, "result count out of range")
    `BBNE_ASSERT_IMPL(a_two_last, r_cnt == 2'd2, !r_slot[0].last && r_slot[1].last, "two-beat order lost its last flag")
    `BBNE_ASSERT_IMPL(a_one_last, r_cnt == 2'd1, r_slot[0].last, "final beat not marked last")

endmodule

/* rtl/bellows_button_note_events.sv */
// Top level: button scans and note loads in, note-on and note-off events out.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | kind, button_index, button_down,
//          |           |                            | bellows_pull, push_note, pull_note
//  out     | output    | o_out_valid / i_out_ready  | event_res, note_number, velocity,
//          |           |                            | pressed, last
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | cfg_index, cfg_data (always ready)
//
// Flow: an accepted beat waits in the input register until the result buffer has room, then the
// event logic writes its results (none for a load, one or two for a scan) into the result buffer,
// which shows the first result. The result buffer gives out a single output beat per cycle while
// i_out_ready is high, and takes in a new beat's results as its last result leaves.
// Reset: synchronous, active low; clears the note tables, sounding flags and configuration
// registers to their defaults (octave 3, velocity 127).
// Stalls: a held output backs up into the input register and then lowers o_in_ready.
`include "bellows_button_note_events_macros.svh"

module bellows_button_note_events import bbne_pkg::*; #(
    parameter int BUTTON_COUNT = DEFAULT_BUTTON_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic [IDX_W-1:0]      i_button_index,
    input  logic                  i_button_down,
    input  logic                  i_bellows_pull,
    input  logic [NOTE_W-1:0]     i_push_note,
    input  logic [NOTE_W-1:0]     i_pull_note,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_event_res,
    output logic [NOTE_W-1:0]     o_note_number,
    output logic [VEL_W-1:0]      o_velocity,
    output logic                  o_pressed,
    output logic                  o_last,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Only buttons reachable by the 4-bit index get storage.
    localparam int DEPTH = (BUTTON_COUNT < INDEX_SPAN) ? BUTTON_COUNT : INDEX_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    logic [OCT_W-1:0] r_octave;
    logic [VEL_W-1:0] r_on_vel;

    // input register
    logic              r_in_valid;
    logic              r_kind;
    logic [IDX_W-1:0]  r_idx;
    logic              r_down;
    logic              r_pull;
    logic [NOTE_W-1:0] r_push_new;
    logic [NOTE_W-1:0] r_pull_new;

    // per-button state
    logic [NOTE_W-1:0] r_push_note [DEPTH];
    logic [NOTE_W-1:0] r_pull_note [DEPTH];
    logic [DEPTH-1:0]  r_push_on;
    logic [DEPTH-1:0]  r_pull_on;
    logic [DEPTH-1:0]  n_push_on;
    logic [DEPTH-1:0]  n_pull_on;

    // event logic
    logic              w_fire;
    logic              w_room;
    logic              w_inr;
    logic [AW-1:0]     w_addr;
    logic [NOTE_W-1:0] w_pn;
    logic [NOTE_W-1:0] w_ln;
    logic              w_ps;
    logic              w_ls;
    logic              w_cur;
    logic              w_oth;
    logic [1:0]        w_count;
    t_result           w_res0;
    t_result           w_res1;
    t_result           w_out;

    assign o_cfg_ready = 1'b1;

    // Decode configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave <= OCTAVE_RESET;
            r_on_vel <= VELOCITY_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OCTAVE:   r_octave <= i_cfg_data[OCT_W-1:0];
                CFG_VELOCITY: r_on_vel <= i_cfg_data[VEL_W-1:0];
                default:      ;
            endcase
        end
    end

    // The input register frees up when its beat goes into the event logic.
    assign w_fire     = r_in_valid && w_room;
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind     <= i_kind;
            r_idx      <= i_button_index;
            r_down     <= i_button_down;
            r_pull     <= i_bellows_pull;
            r_push_new <= i_push_note;
            r_pull_new <= i_pull_note;
        end
    end

    // Look up the addressed button; an index past the table reads as unused.
    assign w_inr  = ((IDX_W + 1)'(r_idx) < (IDX_W + 1)'(DEPTH));
    assign w_addr = AW'(r_idx);
    assign w_pn   = w_inr ? r_push_note[w_addr] : '0;
    assign w_ln   = w_inr ? r_pull_note[w_addr] : '0;
    assign w_ps   = w_inr && r_push_on[w_addr];
    assign w_ls   = w_inr && r_pull_on[w_addr];
    // sounding flag of the current bellows direction, and of the other one
    assign w_cur  = r_pull ? w_ls : w_ps;
    assign w_oth  = r_pull ? w_ps : w_ls;

    always_comb begin
        w_count   = 2'd0;
        w_res0    = '{ev: EV_NONE, note: '0, vel: '0, pressed: r_down, last: 1'b1};
        w_res1    = '{ev: EV_NONE, note: '0, vel: '0, pressed: r_down, last: 1'b1};
        n_push_on = r_push_on;
        n_pull_on = r_pull_on;
        case (r_kind)
            KIND_SCAN: begin
                // A scan always yields at least the pressed echo.
                w_count = 2'd1;
                if (w_inr && ((w_pn != '0) || (w_ln != '0))) begin
                    if (r_down) begin
                        if (!w_cur) begin
                            // Start the note for this direction, then stop the other.
                            w_res0.ev   = EV_ON;
                            w_res0.note = shift_note(r_pull ? w_ln : w_pn, r_octave);
                            w_res0.vel  = r_on_vel;
                            w_res0.last = !w_oth;
                            w_res1.ev   = EV_OFF;
                            w_res1.note = shift_note(r_pull ? w_pn : w_ln, r_octave);
                            w_count     = w_oth ? 2'd2 : 2'd1;
                            n_push_on[w_addr] = !r_pull;
                            n_pull_on[w_addr] = r_pull;
                        end
                    end else begin
                        // Release: push note-off first, then pull.
                        if (w_ps) begin
                            w_res0.ev   = EV_OFF;
                            w_res0.note = shift_note(w_pn, r_octave);
                            w_res0.last = !w_ls;
                            if (w_ls) begin
                                w_res1.ev   = EV_OFF;
                                w_res1.note = shift_note(w_ln, r_octave);
                                w_count     = 2'd2;
                            end
                        end else if (w_ls) begin
                            w_res0.ev   = EV_OFF;
                            w_res0.note = shift_note(w_ln, r_octave);
                        end
                        n_push_on[w_addr] = 1'b0;
                        n_pull_on[w_addr] = 1'b0;
                    end
                end
            end
            KIND_LOAD: begin
                w_count = 2'd0;
            end
            default: begin
                w_count = 2'd0;
            end
        endcase
    end

    // Commit the button state in the same cycle the results enter the buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push_on <= '0;
            r_pull_on <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                r_push_note[i] <= '0;
                r_pull_note[i] <= '0;
            end
        end else if (w_fire) begin
            r_push_on <= n_push_on;
            r_pull_on <= n_pull_on;
            if ((r_kind == KIND_LOAD) && w_inr) begin
                r_push_note[w_addr] <= r_push_new;
                r_pull_note[w_addr] <= r_pull_new;
            end
        end
    end

    bbne_res_buf u_res_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_count (w_count),
        .i_res0  (w_res0),
        .i_res1  (w_res1),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (w_out)
    );

    assign o_event_res   = w_out.ev;
    assign o_note_number = w_out.note;
    assign o_velocity    = w_out.vel;
    assign o_pressed     = w_out.pressed;
    assign o_last        = w_out.last;

    `BBNE_ASSERT_ALWAYS(a_one_dir, (r_push_on & r_pull_on) == '0, "button sounds both directions")
    `BBNE_ASSERT_IMPL(a_off_vel, o_out_valid && (o_event_res == EV_OFF), o_velocity == '0, "note-off with velocity")
    `BBNE_ASSERT_NEXT(a_scan_out, w_fire && (r_kind == KIND_SCAN), o_out_valid, "scan produced no result")

endmodule
